@@ sv/escape_sequence_decoder_assert.svh @@
// Assertion macros shared by the decoder modules.
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ESD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ESD_ASSERT_NOW(lbl, ante, cons, msg)

`define ESD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/esd_pkg.sv @@
`default_nettype none

package esd_pkg;

  localparam int unsigned OUT_DEPTH = 4;
  localparam logic [7:0] WAIT_CODE_RESET = 8'd96;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data_byte;
  } result_t;

  typedef struct packed {
    logic [1:0]       cnt;
    result_t [1:0]    res;
  } push_t;

endpackage

`default_nettype wire

@@ sv/esd_decode.sv @@
`default_nettype none

`include "escape_sequence_decoder_assert.svh"

module esd_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            acc,
  input  wire logic [7:0]      in_char,
  input  wire logic            last,
  input  wire logic            cfg_wr_en,
  input  wire logic [7:0]      cfg_wr_data,
  output esd_pkg::push_t       push
);
  import esd_pkg::*;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_CARET  = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_OCT1   = 3'd5,
    MODE_OCT2   = 3'd6
  } mode_t;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam logic [7:0] BYTE_BSL   = 8'd92;
  localparam logic [7:0] BYTE_CARET = 8'd94;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_BS    = 8'd8;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] CARET_MASK = 8'o037;

  function automatic logic [5:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + 8'd10;
    end
    return t[5:0];
  endfunction

  function automatic logic [3:0] oct_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end
    return t[3:0];
  endfunction

  mode_t      mode_r, mode_nxt, mode_mid;
  logic [7:0] partial_r, partial_nxt, partial_mid;
  logic [7:0] wait_code_r;
  logic       main_v;
  logic [7:0] main_b;
  logic       numeric;
  logic [5:0] hv;
  logic [3:0] ov;

  assign hv = hex_val(in_char);
  assign ov = oct_val(in_char);

  always_comb begin
    mode_mid    = MODE_NORMAL;
    partial_mid = partial_r;
    main_v      = 1'b0;
    main_b      = in_char;
    unique case (mode_r)
      MODE_ESC: begin
        unique case (in_char)
          CH_X: begin
            partial_mid = 8'd0;
            mode_mid    = MODE_HEX1;
          end
          CH_W: begin
            main_v = 1'b1;
            main_b = wait_code_r;
          end
          CH_BSL: begin
            main_v = 1'b1;
            main_b = BYTE_BSL;
          end
          CH_CARET: begin
            main_v = 1'b1;
            main_b = BYTE_CARET;
          end
          CH_S: begin
            main_v = 1'b1;
            main_b = BYTE_SPACE;
          end
          CH_E: begin
            main_v = 1'b1;
            main_b = BYTE_ESC;
          end
          CH_B: begin
            main_v = 1'b1;
            main_b = BYTE_BS;
          end
          CH_N: begin
            main_v = 1'b1;
            main_b = BYTE_LF;
          end
          CH_R: begin
            main_v = 1'b1;
            main_b = BYTE_CR;
          end
          CH_T: begin
            main_v = 1'b1;
            main_b = BYTE_TAB;
          end
          CH_0, CH_1, CH_2, CH_3: begin
            partial_mid = {in_char[1:0], 6'd0};
            mode_mid    = MODE_OCT1;
          end
          default: begin
          end
        endcase
      end
      MODE_CARET: begin
        main_v = 1'b1;
        main_b = in_char & CARET_MASK;
      end
      MODE_HEX1: begin
        partial_mid = {hv[3:0], 4'd0};
        mode_mid    = MODE_HEX2;
      end
      MODE_HEX2: begin
        main_v      = 1'b1;
        main_b      = partial_r + {2'd0, hv};
        partial_mid = 8'd0;
      end
      MODE_OCT1: begin
        partial_mid = partial_r + {1'b0, ov, 3'd0};
        mode_mid    = MODE_OCT2;
      end
      MODE_OCT2: begin
        main_v      = 1'b1;
        main_b      = partial_r + {4'd0, ov};
        partial_mid = 8'd0;
      end
      default: begin
        if (in_char == CH_BSL) begin
          mode_mid = MODE_ESC;
        end else if (in_char == CH_CARET) begin
          mode_mid = MODE_CARET;
        end else begin
          main_v = 1'b1;
        end
      end
    endcase
  end

  assign numeric = (mode_mid == MODE_HEX1) || (mode_mid == MODE_HEX2) ||
                   (mode_mid == MODE_OCT1) || (mode_mid == MODE_OCT2);

  always_comb begin
    push.cnt              = 2'd0;
    push.res[0].is_end    = 1'b0;
    push.res[0].data_byte = main_b;
    push.res[1].is_end    = 1'b1;
    push.res[1].data_byte = 8'd0;
    mode_nxt              = mode_mid;
    partial_nxt           = partial_mid;
    if (last) begin
      mode_nxt    = MODE_NORMAL;
      partial_nxt = 8'd0;
    end
    if (acc) begin
      priority if (main_v) begin
        push.cnt = last ? 2'd2 : 2'd1;
      end else if (last && numeric) begin
        push.cnt              = 2'd2;
        push.res[0].data_byte = partial_mid;
      end else if (last) begin
        push.cnt              = 2'd1;
        push.res[0].is_end    = 1'b1;
        push.res[0].data_byte = 8'd0;
      end else begin
        push.cnt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      partial_r   <= 8'd0;
      wait_code_r <= WAIT_CODE_RESET;
    end else begin
      if (acc) begin
        mode_r    <= mode_nxt;
        partial_r <= partial_nxt;
      end
      if (cfg_wr_en) begin
        wait_code_r <= cfg_wr_data;
      end
    end
  end

  `ESD_ASSERT_NEXT(a_last_clears, acc && last, mode_r == MODE_NORMAL && partial_r == 8'd0, "state not cleared after last word")
  `ESD_ASSERT_NOW(a_second_is_end, push.cnt == 2'd2, push.res[1].is_end && !push.res[0].is_end, "second result is not the terminator")
  `ESD_ASSERT_NEXT(a_hex_step, acc && !last && mode_r == MODE_HEX1, mode_r == MODE_HEX2, "first hex digit not followed by second")

endmodule

`default_nettype wire

@@ sv/esd_out_fifo.sv @@
`default_nettype none

`include "escape_sequence_decoder_assert.svh"

module esd_out_fifo #(
  parameter int unsigned Depth = esd_pkg::OUT_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire esd_pkg::push_t  push,
  output logic                 space,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);
  import esd_pkg::*;

  localparam int unsigned PTR_W = $clog2(Depth);
  localparam int unsigned CNT_W = $clog2(Depth + 1);
  localparam logic [CNT_W-1:0] SPACE_LIM = CNT_W'(Depth - 2);

  result_t           mem [Depth];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_p1;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pop;

  assign space      = count_r <= SPACE_LIM;
  assign out_tvalid = count_r != '0;
  assign out_tdata  = mem[rd_ptr_r].data_byte;
  assign out_tlast  = mem[rd_ptr_r].is_end;
  assign pop        = out_tvalid && out_tready;
  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.res[0];
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ESD_ASSERT_NOW(a_no_overflow, 1'b1, count_r <= CNT_W'(Depth), "output queue overflow")
  `ESD_ASSERT_NOW(a_push_room, push.cnt != 2'd0, count_r <= SPACE_LIM, "push without room for two words")
  `ESD_ASSERT_NEXT(a_idle_count, push.cnt == 2'd0 && !pop, $stable(count_r), "count moved without push or pop")

endmodule

`default_nettype wire

@@ sv/escape_sequence_decoder.sv @@
`default_nettype none

// Result words are registered in the output queue and offered from its head.
// Throughput: one input word per cycle while the output queue has room for two
// words; a word that yields a byte plus the terminator pushes two words, so a
// run of such words stalls the input down to the output rate.
// Reset (rst_n low, synchronous): decoder returns to plain text, partial byte 0,
// wait code 96, output queue empty.
module escape_sequence_decoder #(
  parameter int unsigned OutDepth = esd_pkg::OUT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] in_char
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] out_byte
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  import esd_pkg::*;

  push_t push;
  logic  space;
  logic  acc;

  assign in_tready = space;
  assign acc       = in_tvalid && space;

  esd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_char     (in_tdata),
    .last        (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push)
  );

  esd_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
